@@ sv/segment_polygon_occlusion_top_macros.svh @@
// Assertion macros for the segment/polygon occlusion block.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef SEGMENT_POLYGON_OCCLUSION_TOP_MACROS_SVH
`define SEGMENT_POLYGON_OCCLUSION_TOP_MACROS_SVH

// condition holds at every clock edge out of reset
`define SGPO_CHECK(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define SGPO_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

@@ sv/sgpo_pkg.sv @@
// Shared types and constants for the segment/polygon occlusion block.
// No dependencies.
package sgpo_pkg;

    localparam int MAX_OBSTACLES = 16;
    localparam int MAX_VERTICES  = 256;
    localparam int COORD_BITS    = 16;

    localparam int VA = $clog2(MAX_VERTICES);
    localparam int VC = $clog2(MAX_VERTICES + 1);
    localparam int OA = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
    localparam int OC = $clog2(MAX_OBSTACLES + 1);
    localparam int OPA_W = 9;

    localparam logic [OPA_W-1:0] OPA_FULL = OPA_W'(256);

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_CLOSE = 2'd1,
        OP_CLEAR = 2'd2,
        OP_QUERY = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_SHORT = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] x;
    } vertex_t;

    typedef struct packed {
        logic [VA-1:0]    first;
        logic [VC-1:0]    count;
        logic [OPA_W-1:0] opacity;
    } obstacle_t;

    typedef struct packed {
        logic       valid;
        logic       first;
    } rd_tag_t;

endpackage

@@ sv/sgpo_vmem.sv @@
// Vertex memory: one write port, one read port, registered read data.
// Depends on sgpo_pkg.
module sgpo_vmem (
    input  logic                   clk,
    input  logic                   we,
    input  logic [sgpo_pkg::VA-1:0] waddr,
    input  sgpo_pkg::vertex_t      wdata,
    input  logic                   re,
    input  logic [sgpo_pkg::VA-1:0] raddr,
    output sgpo_pkg::vertex_t      rdata
);
    import sgpo_pkg::*;

    vertex_t mem [MAX_VERTICES];
    vertex_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/sgpo_edge.sv @@
// Two-stage inclusive segment/edge touch test (products, then signs).
// Depends on sgpo_pkg.
module sgpo_edge (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  sgpo_pkg::vertex_t qa,
    input  sgpo_pkg::vertex_t qb,
    input  sgpo_pkg::vertex_t p,
    input  sgpo_pkg::vertex_t q,
    output logic              hit_valid,
    output logic              hit
);
    import sgpo_pkg::*;

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int SW = PW + 1;

    logic signed [DW-1:0] dx0, dy0, dx1, dy1;
    logic signed [DW-1:0] ex0, ey0, ex1, ey1, ex2, ey2, ex3, ey3;
    logic signed [PW-1:0] pr_next [8];
    logic signed [PW-1:0] pr_reg [8];
    logic signed [SW-1:0] s0, s1, s2, s3;
    logic                 v1_reg, v2_reg, hit_reg;
    logic                 ok01, ok23;

    always_comb
    begin
        dx0 = DW'(qb.x) - DW'(qa.x);
        dy0 = DW'(qb.y) - DW'(qa.y);
        dx1 = DW'(q.x) - DW'(p.x);
        dy1 = DW'(q.y) - DW'(p.y);
        ex0 = DW'(q.x) - DW'(qa.x);
        ey0 = DW'(q.y) - DW'(qa.y);
        ex1 = DW'(q.x) - DW'(qb.x);
        ey1 = DW'(q.y) - DW'(qb.y);
        ex2 = DW'(qb.x) - DW'(p.x);
        ey2 = DW'(qb.y) - DW'(p.y);
        ex3 = DW'(qb.x) - DW'(q.x);
        ey3 = DW'(qb.y) - DW'(q.y);
        pr_next[0] = PW'(dy1) * PW'(ex0);
        pr_next[1] = PW'(dx1) * PW'(ey0);
        pr_next[2] = PW'(dy1) * PW'(ex1);
        pr_next[3] = PW'(dx1) * PW'(ey1);
        pr_next[4] = PW'(dy0) * PW'(ex2);
        pr_next[5] = PW'(dx0) * PW'(ey2);
        pr_next[6] = PW'(dy0) * PW'(ex3);
        pr_next[7] = PW'(dx0) * PW'(ey3);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 8; i++)
        begin
            pr_reg[i] <= pr_next[i];
        end
    end

    always_comb
    begin
        s0 = SW'(pr_reg[0]) - SW'(pr_reg[1]);
        s1 = SW'(pr_reg[2]) - SW'(pr_reg[3]);
        s2 = SW'(pr_reg[4]) - SW'(pr_reg[5]);
        s3 = SW'(pr_reg[6]) - SW'(pr_reg[7]);
        // signs must not agree strictly (zero on either side counts)
        ok01 = !((s0 > 0 && s1 > 0) || (s0 < 0 && s1 < 0));
        ok23 = !((s2 > 0 && s3 > 0) || (s2 < 0 && s3 < 0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg <= ok01 && ok23;
    end

    assign hit_valid = v2_reg;
    assign hit       = hit_reg;

endmodule

@@ sv/segment_polygon_occlusion_top.sv @@
// Segment occlusion by polygon obstacles: top level, control and obstacle table.
// Depends on sgpo_pkg, sgpo_vmem, sgpo_edge and the assertion macro header.
//
// Add, close and clear words go from idle to the finish state. A query walks
// the vertex memory one read per cycle: each non-transparent obstacle with n
// vertices, until a fully opaque one is hit, takes a setup step, n + 1 reads
// incl. the closing edge, a pipeline drain and an accumulate step; every other
// obstacle is just skipped. The single vertex-memory read port bounds the query
// time. A finished result sits in the output register while the next word is
// taken.
`include "segment_polygon_occlusion_top_macros.svh"
module segment_polygon_occlusion_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,  // ax[15:0], ay, bx, by, obstacle_opacity[8:0], zero pad
    input  logic [1:0]  s_tuser,  // opcode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata   // occlusion[8:0], any_hit, status[1:0], zero pad
);
    import sgpo_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_OBJ,
        S_READ,
        S_DRAIN,
        S_APPLY,
        S_FINISH
    } state_t;

    state_t            state_reg, state_next;
    logic [VC-1:0]     vt_reg, vt_next;
    logic [VC-1:0]     os_reg, os_next;
    logic [OC-1:0]     ot_reg, ot_next;
    obstacle_t         tbl_reg [MAX_OBSTACLES];
    vertex_t           qa_reg, qa_next, qb_reg, qb_next;
    logic [OC-1:0]     obj_reg, obj_next;
    logic [VC-1:0]     rdc_reg, rdc_next;
    obstacle_t         ent_reg, ent_next;
    logic [1:0]        drain_reg, drain_next;
    logic              ohit_reg, ohit_next;
    logic              hit_reg, hit_next;
    logic              blk_reg, blk_next;
    logic [OPA_W-1:0]  trans_reg, trans_next;
    logic [OPA_W-1:0]  occ_reg, occ_next;
    logic              ahit_reg, ahit_next;
    status_t           sts_reg, sts_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [15:0]       m_tdata_reg, m_tdata_next;

    logic              tbl_we;
    obstacle_t         tbl_wdata;
    obstacle_t         ent_rd;
    logic              mem_we, mem_re;
    logic [VA-1:0]     mem_raddr;
    vertex_t           mem_wdata, mem_rdata;
    rd_tag_t           tag_reg, tag_next;
    vertex_t           prev_reg;
    logic              e_valid, e_hit;
    logic              e_valid_out;
    logic              accept;
    logic [VC:0]       open_n;
    logic [OPA_W-1:0]  opa_in;
    logic [2*OPA_W-1:0] tprod;
    opcode_t           op;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign op       = opcode_t'(s_tuser);
    assign open_n   = {1'b0, vt_reg} - {1'b0, os_reg};
    assign opa_in   = (s_tdata[72:64] > OPA_FULL) ? OPA_FULL : s_tdata[72:64];
    assign ent_rd   = tbl_reg[obj_reg[OA-1:0]];
    assign tprod    = trans_reg * (OPA_FULL - ent_reg.opacity);
    assign mem_wdata = '{y: s_tdata[31:16], x: s_tdata[15:0]};

    always_comb
    begin
        state_next    = state_reg;
        vt_next       = vt_reg;
        os_next       = os_reg;
        ot_next       = ot_reg;
        qa_next       = qa_reg;
        qb_next       = qb_reg;
        obj_next      = obj_reg;
        rdc_next      = rdc_reg;
        ent_next      = ent_reg;
        drain_next    = drain_reg;
        ohit_next     = ohit_reg | (e_valid_out & e_hit);
        hit_next      = hit_reg;
        blk_next      = blk_reg;
        trans_next    = trans_reg;
        occ_next      = occ_reg;
        ahit_next     = ahit_reg;
        sts_next      = sts_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        tbl_we        = 1'b0;
        tbl_wdata     = '{first: os_reg[VA-1:0], count: open_n[VC-1:0], opacity: opa_in};
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        mem_raddr     = ent_reg.first + rdc_reg[VA-1:0];
        tag_next      = '{valid: 1'b0, first: 1'b0};

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    occ_next   = '0;
                    ahit_next  = 1'b0;
                    sts_next   = ST_OK;
                    state_next = S_FINISH;
                    case (op)
                        OP_ADD:
                        begin
                            if (vt_reg >= VC'(MAX_VERTICES))
                            begin
                                sts_next = ST_FULL;
                            end
                            else
                            begin
                                mem_we  = 1'b1;
                                vt_next = vt_reg + 1'b1;
                            end
                        end
                        OP_CLOSE:
                        begin
                            if (vt_reg < os_reg || open_n < (VC+1)'(3))
                            begin
                                sts_next = ST_SHORT;
                            end
                            else if (ot_reg >= OC'(MAX_OBSTACLES))
                            begin
                                sts_next = ST_FULL;
                            end
                            else
                            begin
                                tbl_we  = 1'b1;
                                ot_next = ot_reg + 1'b1;
                                os_next = vt_reg;
                            end
                        end
                        OP_CLEAR:
                        begin
                            vt_next = '0;
                            os_next = '0;
                            ot_next = '0;
                        end
                        default:
                        begin
                            qa_next    = '{y: s_tdata[31:16], x: s_tdata[15:0]};
                            qb_next    = '{y: s_tdata[63:48], x: s_tdata[47:32]};
                            obj_next   = '0;
                            trans_next = OPA_FULL;
                            hit_next   = 1'b0;
                            blk_next   = 1'b0;
                            state_next = S_OBJ;
                        end
                    endcase
                end
            end
            S_OBJ:
            begin
                if (obj_reg == ot_reg)
                begin
                    if (blk_reg)
                    begin
                        occ_next = OPA_FULL;
                    end
                    else if (hit_reg)
                    begin
                        occ_next = OPA_FULL - trans_reg;
                    end
                    ahit_next  = hit_reg;
                    state_next = S_FINISH;
                end
                else if (ent_rd.opacity == '0 || blk_reg)
                begin
                    obj_next = obj_reg + 1'b1;
                end
                else
                begin
                    ent_next   = ent_rd;
                    rdc_next   = '0;
                    ohit_next  = 1'b0;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                mem_re   = 1'b1;
                tag_next = '{valid: 1'b1, first: (rdc_reg == '0)};
                if (rdc_reg == ent_reg.count)
                begin
                    // closing edge: back to the first vertex
                    mem_raddr  = ent_reg.first;
                    drain_next = '0;
                    state_next = S_DRAIN;
                end
                else
                begin
                    rdc_next = rdc_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                drain_next = drain_reg + 1'b1;
                if (drain_reg == 2'd2)
                begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                if (ohit_reg)
                begin
                    hit_next = 1'b1;
                    if (ent_reg.opacity >= OPA_FULL)
                    begin
                        blk_next = 1'b1;
                    end
                    else
                    begin
                        trans_next = tprod[OPA_W+7:8];
                    end
                end
                obj_next   = obj_reg + 1'b1;
                state_next = S_OBJ;
            end
            S_FINISH:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {4'b0, sts_reg, ahit_reg, occ_reg};
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            vt_reg       <= '0;
            os_reg       <= '0;
            ot_reg       <= '0;
            obj_reg      <= '0;
            rdc_reg      <= '0;
            drain_reg    <= '0;
            ohit_reg     <= 1'b0;
            hit_reg      <= 1'b0;
            blk_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
            tag_reg      <= '{valid: 1'b0, first: 1'b0};
        end
        else
        begin
            state_reg    <= state_next;
            vt_reg       <= vt_next;
            os_reg       <= os_next;
            ot_reg       <= ot_next;
            obj_reg      <= obj_next;
            rdc_reg      <= rdc_next;
            drain_reg    <= drain_next;
            ohit_reg     <= ohit_next;
            hit_reg      <= hit_next;
            blk_reg      <= blk_next;
            m_tvalid_reg <= m_tvalid_next;
            tag_reg      <= tag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        qa_reg      <= qa_next;
        qb_reg      <= qb_next;
        ent_reg     <= ent_next;
        trans_reg   <= trans_next;
        occ_reg     <= occ_next;
        ahit_reg    <= ahit_next;
        sts_reg     <= sts_next;
        m_tdata_reg <= m_tdata_next;
        if (tag_reg.valid)
        begin
            prev_reg <= mem_rdata;
        end
        if (tbl_we)
        begin
            tbl_reg[ot_reg[OA-1:0]] <= tbl_wdata;
        end
    end

    sgpo_vmem u_vmem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (vt_reg[VA-1:0]),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // an edge is formed by the previous and the current vertex read
    assign e_valid = tag_reg.valid && !tag_reg.first;

    sgpo_edge u_edge (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (e_valid),
        .qa        (qa_reg),
        .qb        (qb_reg),
        .p         (prev_reg),
        .q         (mem_rdata),
        .hit_valid (e_valid_out),
        .hit       (e_hit)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `SGPO_CHECK(a_vt_bound, vt_reg <= VC'(MAX_VERTICES), "vertex count overflow")
    `SGPO_CHECK(a_open_order, os_reg <= vt_reg, "open start beyond vertex count")
    `SGPO_CHECK(a_ot_bound, ot_reg <= OC'(MAX_OBSTACLES), "obstacle count overflow")
    `SGPO_IMPLY(a_idle_no_read, s_tready, !tag_reg.valid && !e_valid_out, "read in flight at idle")
    `SGPO_IMPLY(a_occ_hit, m_tvalid && m_tdata[8:0] != 9'd0, m_tdata[9], "occlusion without hit")

endmodule
